// File: hdl/finite_radix_fraction_check_top_defines.svh
// assertion macros for the finite radix fraction check
`ifndef FINITE_RADIX_FRACTION_CHECK_TOP_DEFINES_SVH
`define FINITE_RADIX_FRACTION_CHECK_TOP_DEFINES_SVH

// condition implies consequence on the next edge
`define FRC_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

// condition implies consequence on the same edge
`define FRC_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// shared types and constants of the finite radix fraction check
// ----------------------------------------------------------------------------
`default_nettype none

package frc_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 48;
    localparam int RADIX_WIDTH_DEFAULT = 16;
    localparam int RADIX_RESET = 10;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GCD_START,
        ST_GCD_WAIT,
        ST_RED_START,
        ST_RED_WAIT,
        ST_TRIAL_TEST,
        ST_TRIAL_START,
        ST_TRIAL_WAIT,
        ST_SDEN_START,
        ST_SDEN_WAIT,
        ST_SBASE_START,
        ST_SBASE_WAIT,
        ST_LEFT_START,
        ST_LEFT_DIV,
        ST_LEFT_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_GCD,
        OP_REDUCE,
        OP_TRIAL,
        OP_STRIP_DEN,
        OP_STRIP_BASE
    } op_t;

    typedef struct packed {
        logic load;
        logic start;
        op_t  op;
        logic trial_next;
        logic fac_base;
        logic finish;
        logic result_invalid;
    } ctrl_t;

    typedef struct packed {
        logic invalid;
        logic trial_over;
        logic leftover;
        logic div_busy;
        logic div_zero_rem;
        logic den_zero;
    } stat_t;

endpackage

`default_nettype wire

// File: hdl/frc_divider.sv
// ----------------------------------------------------------------------------
// frc_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module frc_divider #(
    parameter int WIDTH = frc_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    output logic                  busy,
    output logic      [WIDTH-1:0] quotient,
    output logic      [WIDTH-1:0] remainder
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    count_reg, count_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [WIDTH:0]   trial;

    always_comb
    begin
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        trial      = {rem_reg, quo_reg[WIDTH-1]};
        if (start)
        begin
            count_next = CW'(WIDTH);
            quo_next   = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - CW'(1);
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = WIDTH'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = (count_reg != '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: hdl/frc_datapath.sv
// ----------------------------------------------------------------------------
// frc_datapath
// value registers, trial factor and shared divider
// ----------------------------------------------------------------------------
`default_nettype none

module frc_datapath #(
    parameter int VALUE_WIDTH = frc_pkg::VALUE_WIDTH_DEFAULT,
    parameter int RADIX_WIDTH = frc_pkg::RADIX_WIDTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire frc_pkg::ctrl_t         ctrl,
    input  wire logic [VALUE_WIDTH-1:0] numerator,
    input  wire logic [VALUE_WIDTH-1:0] denominator,
    input  wire logic [RADIX_WIDTH-1:0] radix,
    output frc_pkg::stat_t              stat,
    output logic                        status,
    output logic                        is_finite_flag
);

    localparam int DW = (VALUE_WIDTH > RADIX_WIDTH) ? VALUE_WIDTH : RADIX_WIDTH;

    logic [DW-1:0]          a_reg, a_next;
    logic [DW-1:0]          den_reg, den_next;
    logic [DW-1:0]          dorig_reg, dorig_next;
    logic [RADIX_WIDTH-1:0] base_reg, base_next;
    logic [RADIX_WIDTH-1:0] fac_reg, fac_next;
    logic                   status_reg, status_next;
    logic                   fin_reg, fin_next;
    logic [DW-1:0]          dvd, dvs, quo, rem;
    logic                   busy;
    logic [2*RADIX_WIDTH-1:0] sq;

    always_comb
    begin
        dvd = '0;
        dvs = DW'(1);
        case (ctrl.op)
            frc_pkg::OP_GCD:
            begin
                dvd = a_reg;
                dvs = den_reg;
            end
            frc_pkg::OP_REDUCE:
            begin
                dvd = dorig_reg;
                dvs = a_reg;
            end
            frc_pkg::OP_TRIAL, frc_pkg::OP_STRIP_BASE:
            begin
                dvd = DW'(base_reg);
                dvs = DW'(fac_reg);
            end
            frc_pkg::OP_STRIP_DEN:
            begin
                dvd = den_reg;
                dvs = DW'(fac_reg);
            end
            default:
            begin
                dvd = '0;
                dvs = DW'(1);
            end
        endcase
    end

    frc_divider #(.WIDTH(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ctrl.start),
        .dividend  (dvd),
        .divisor   (dvs),
        .busy      (busy),
        .quotient  (quo),
        .remainder (rem)
    );

    // gcd step: a <- den, den <- a mod den; reduce: den <- original den / gcd
    always_comb
    begin
        a_next      = a_reg;
        den_next    = den_reg;
        dorig_next  = dorig_reg;
        base_next   = base_reg;
        fac_next    = fac_reg;
        status_next = status_reg;
        fin_next    = fin_reg;
        if (ctrl.load)
        begin
            a_next     = DW'(numerator);
            den_next   = DW'(denominator);
            dorig_next = DW'(denominator);
            base_next  = radix;
            fac_next   = RADIX_WIDTH'(2);
        end
        if (ctrl.trial_next)
            fac_next = fac_reg + RADIX_WIDTH'(1);
        if (ctrl.fac_base)
            fac_next = base_reg;
        if (!busy && !ctrl.start)
        begin
            case (ctrl.op)
                frc_pkg::OP_GCD:
                begin
                    a_next   = den_reg;
                    den_next = rem;
                end
                frc_pkg::OP_REDUCE:    den_next = quo;
                frc_pkg::OP_STRIP_DEN:
                    if (rem == '0)
                        den_next = quo;
                frc_pkg::OP_STRIP_BASE:
                    if (rem == '0)
                        base_next = quo[RADIX_WIDTH-1:0];
                default:               ;
            endcase
        end
        if (ctrl.finish)
        begin
            status_next = ctrl.result_invalid;
            fin_next    = !ctrl.result_invalid && (den_reg == DW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        den_reg   <= den_next;
        dorig_reg <= dorig_next;
        base_reg  <= base_next;
        fac_reg   <= fac_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= 1'b0;
            fin_reg    <= 1'b0;
        end
        else
        begin
            status_reg <= status_next;
            fin_reg    <= fin_next;
        end
    end

    assign sq = fac_reg * fac_reg;

    assign stat.invalid      = (radix < RADIX_WIDTH'(2)) || (numerator == '0)
                             || (denominator == '0) || (numerator >= denominator);
    assign stat.trial_over   = (sq > (2*RADIX_WIDTH)'(base_reg)) || (fac_reg == '1);
    assign stat.leftover     = (base_reg > RADIX_WIDTH'(1));
    assign stat.div_busy     = busy;
    assign stat.div_zero_rem = (rem == '0);
    assign stat.den_zero     = (den_reg == '0);

    assign status         = status_reg;
    assign is_finite_flag = fin_reg;

endmodule

`default_nettype wire

// File: hdl/frc_controller.sv
// ----------------------------------------------------------------------------
// frc_controller
// sequencer for gcd, reduction and factor stripping
// ----------------------------------------------------------------------------
`default_nettype none

module frc_controller (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire frc_pkg::stat_t stat,
    output frc_pkg::ctrl_t      ctrl
);

    frc_pkg::state_t state_reg, state_next;
    logic            inv_reg, inv_next;
    logic            ov_reg, ov_next;
    logic            done_div;

    assign done_div = !stat.div_busy;

    always_comb
    begin
        state_next = state_reg;
        inv_next   = inv_reg;
        unique case (state_reg)
            frc_pkg::ST_IDLE:
                if (in_valid && in_ready)
                begin
                    state_next = frc_pkg::ST_CHECK;
                    inv_next   = stat.invalid;
                end
            frc_pkg::ST_CHECK:
                state_next = inv_reg ? frc_pkg::ST_DONE : frc_pkg::ST_GCD_START;
            frc_pkg::ST_GCD_START:
                state_next = stat.den_zero ? frc_pkg::ST_RED_START : frc_pkg::ST_GCD_WAIT;
            frc_pkg::ST_GCD_WAIT:
                if (done_div)
                    state_next = frc_pkg::ST_GCD_START;
            frc_pkg::ST_RED_START:
                state_next = frc_pkg::ST_RED_WAIT;
            frc_pkg::ST_RED_WAIT:
                if (done_div)
                    state_next = frc_pkg::ST_TRIAL_TEST;
            frc_pkg::ST_TRIAL_TEST:
                state_next = stat.trial_over ? frc_pkg::ST_LEFT_START
                                             : frc_pkg::ST_TRIAL_START;
            frc_pkg::ST_TRIAL_START:
                state_next = frc_pkg::ST_TRIAL_WAIT;
            frc_pkg::ST_TRIAL_WAIT:
                if (done_div)
                    state_next = stat.div_zero_rem ? frc_pkg::ST_SDEN_START
                                                   : frc_pkg::ST_TRIAL_TEST;
            frc_pkg::ST_SDEN_START:
                state_next = frc_pkg::ST_SDEN_WAIT;
            frc_pkg::ST_SDEN_WAIT:
                if (done_div)
                    state_next = stat.div_zero_rem ? frc_pkg::ST_SDEN_START
                                                   : frc_pkg::ST_SBASE_START;
            frc_pkg::ST_SBASE_START:
                state_next = frc_pkg::ST_SBASE_WAIT;
            frc_pkg::ST_SBASE_WAIT:
                if (done_div)
                    state_next = stat.div_zero_rem ? frc_pkg::ST_SBASE_START
                                                   : frc_pkg::ST_TRIAL_TEST;
            frc_pkg::ST_LEFT_START:
                state_next = stat.leftover ? frc_pkg::ST_LEFT_DIV : frc_pkg::ST_DONE;
            frc_pkg::ST_LEFT_DIV:
                state_next = frc_pkg::ST_LEFT_WAIT;
            frc_pkg::ST_LEFT_WAIT:
                if (done_div)
                    state_next = stat.div_zero_rem ? frc_pkg::ST_LEFT_DIV
                                                   : frc_pkg::ST_DONE;
            frc_pkg::ST_DONE:
                state_next = frc_pkg::ST_IDLE;
            default:
                state_next = frc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl    = '0;
        ctrl.op = frc_pkg::OP_NONE;
        ov_next = ov_reg;
        if (out_valid && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            frc_pkg::ST_IDLE:
                ctrl.load = in_valid && in_ready;
            frc_pkg::ST_GCD_START:
                if (!stat.den_zero)
                begin
                    ctrl.start = 1'b1;
                    ctrl.op    = frc_pkg::OP_GCD;
                end
            frc_pkg::ST_GCD_WAIT:
                ctrl.op = frc_pkg::OP_GCD;
            frc_pkg::ST_RED_START:
            begin
                ctrl.start = 1'b1;
                ctrl.op    = frc_pkg::OP_REDUCE;
            end
            frc_pkg::ST_RED_WAIT:
                ctrl.op = frc_pkg::OP_REDUCE;
            frc_pkg::ST_TRIAL_START:
            begin
                ctrl.start = 1'b1;
                ctrl.op    = frc_pkg::OP_TRIAL;
            end
            frc_pkg::ST_TRIAL_WAIT:
            begin
                ctrl.op         = frc_pkg::OP_TRIAL;
                ctrl.trial_next = done_div && !stat.div_zero_rem;
            end
            frc_pkg::ST_SDEN_START:
            begin
                ctrl.start = 1'b1;
                ctrl.op    = frc_pkg::OP_STRIP_DEN;
            end
            frc_pkg::ST_SDEN_WAIT:
                ctrl.op = frc_pkg::OP_STRIP_DEN;
            frc_pkg::ST_SBASE_START:
            begin
                ctrl.start = 1'b1;
                ctrl.op    = frc_pkg::OP_STRIP_BASE;
            end
            frc_pkg::ST_SBASE_WAIT:
            begin
                ctrl.op         = frc_pkg::OP_STRIP_BASE;
                ctrl.trial_next = done_div && !stat.div_zero_rem;
            end
            frc_pkg::ST_LEFT_START:
                ctrl.fac_base = stat.leftover;
            frc_pkg::ST_LEFT_DIV:
            begin
                ctrl.start = 1'b1;
                ctrl.op    = frc_pkg::OP_STRIP_DEN;
            end
            frc_pkg::ST_LEFT_WAIT:
                ctrl.op = frc_pkg::OP_STRIP_DEN;
            frc_pkg::ST_DONE:
            begin
                ctrl.finish         = 1'b1;
                ctrl.result_invalid = inv_reg;
                ov_next             = 1'b1;
            end
            default:
                ctrl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= frc_pkg::ST_IDLE;
            inv_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            inv_reg   <= inv_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_ready  = (state_reg == frc_pkg::ST_IDLE) && !(ov_reg && !out_ready);
    assign out_valid = ov_reg;

endmodule

`default_nettype wire

// File: hdl/finite_radix_fraction_check_top.sv
// ----------------------------------------------------------------------------
// finite_radix_fraction_check_top
// decides whether numerator/denominator has a finite expansion in radix
// ----------------------------------------------------------------------------
//  channel   signals                              direction
//  in        in_valid in_ready numerator denominator  request in
//  out       out_valid out_ready status is_finite_flag  result out
//  cfg       cfg_valid cfg_ready cfg_data            radix write
//
//  one request at a time; invalid requests go from the check state straight to done
//  all divisions share one divider of width max(VALUE_WIDTH, RADIX_WIDTH)
//  worst case about 70 gcd steps, 255 trial divisions and the stripping
//  divisions per request at the default widths
//  reset sets radix to 10 and empties the output register
//  a held result blocks the next request only while out_ready is low
// ----------------------------------------------------------------------------
`default_nettype none

`include "finite_radix_fraction_check_top_defines.svh"

module finite_radix_fraction_check_top #(
    parameter int VALUE_WIDTH = frc_pkg::VALUE_WIDTH_DEFAULT,
    parameter int RADIX_WIDTH = frc_pkg::RADIX_WIDTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [VALUE_WIDTH-1:0] numerator,
    input  wire logic [VALUE_WIDTH-1:0] denominator,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        status,
    output logic                        is_finite_flag,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [RADIX_WIDTH-1:0] cfg_data
);

    logic [RADIX_WIDTH-1:0] radix_reg;
    frc_pkg::ctrl_t         ctrl;
    frc_pkg::stat_t         stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_WIDTH'(frc_pkg::RADIX_RESET);
        else if (cfg_valid)
            radix_reg <= cfg_data;
    end

    frc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    frc_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .RADIX_WIDTH (RADIX_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .numerator      (numerator),
        .denominator    (denominator),
        .radix          (radix_reg),
        .stat           (stat),
        .status         (status),
        .is_finite_flag (is_finite_flag)
    );

    `FRC_ASSERT_SAME(a_invalid_not_finite, clk, rst_n, out_valid && status, !is_finite_flag)
    `FRC_ASSERT_NEXT(a_held_result, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(is_finite_flag))
    `FRC_ASSERT_SAME(a_no_accept_while_held, clk, rst_n, out_valid && !out_ready, !in_ready)

endmodule

`default_nettype wire

// File: tb/finite_radix_fraction_check_top_tb.sv
// ----------------------------------------------------------------------------
// finite_radix_fraction_check_top_tb
// checks the finite expansion test against a behavioral predictor over
// directed corner requests, random fractions built from radix factors and
// noise, several radix settings and varied idling on both channels
// ----------------------------------------------------------------------------
`default_nettype none

class frc_scoreboard;
    logic [1:0]  finite_q[$];
    int          errors;
    int          checked;

    function void note_request(logic [47:0] num, logic [47:0] den, logic [15:0] base);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        logic [63:0] d;
        logic [63:0] rb;
        logic [63:0] i;
        if (base < 2 || num == 0 || den == 0 || num >= den)
        begin
            finite_q.push_back(2'b10);
            return;
        end
        a = num;
        b = den;
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        d = den / a;
        rb = base;
        for (i = 2; i * i <= rb; i++)
        begin
            if (rb % i == 0)
            begin
                while (d % i == 0) d = d / i;
                while (rb % i == 0) rb = rb / i;
            end
        end
        if (rb > 1)
            while (d % rb == 0) d = d / rb;
        finite_q.push_back({1'b0, d == 1});
    endfunction

    function void check_result(logic st, logic fin);
        logic [1:0] e;
        if (finite_q.size() == 0)
        begin
            $error("unexpected result status=%0d is_finite_flag=%0d", st, fin);
            errors++;
            return;
        end
        e = finite_q.pop_front();
        checked++;
        if (st !== e[1])
        begin
            $error("status expected %0d actual %0d", e[1], st);
            errors++;
        end
        if (fin !== e[0])
        begin
            $error("is_finite_flag expected %0d actual %0d", e[0], fin);
            errors++;
        end
    endfunction
endclass

module finite_radix_fraction_check_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [47:0] numerator = 0;
    logic [47:0] denominator = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic        status;
    logic        is_finite_flag;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 0;

    frc_scoreboard sb = new();
    logic [15:0] radix_now = frc_pkg::RADIX_RESET;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          hold_off = 0;
    int          sent = 0;

    finite_radix_fraction_check_top #(.VALUE_WIDTH(48), .RADIX_WIDTH(16)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .numerator(numerator), .denominator(denominator),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .is_finite_flag(is_finite_flag),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, is_finite_flag);
    end

    task automatic send_request(logic [47:0] num, logic [47:0] den);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        numerator <= num;
        denominator <= den;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(num, den, radix_now);
        sent++;
    endtask

    task automatic write_radix(logic [15:0] value);
        in_valid <= 0;
        while (sb.finite_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        radix_now = value;
    endtask

    function automatic logic [47:0] smooth_value(logic [15:0] base);
        logic [47:0] v;
        int          n;
        v = 1;
        n = int'($urandom_range(20));
        for (int k = 0; k < n; k++)
        begin
            if (v > 48'h0000_FFFF_FFFF) break;
            if ($urandom_range(3) == 0) v = v * 48'($urandom_range(2, 7));
            else v = v * ((base < 2) ? 48'd2 : 48'(base));
        end
        return v;
    endfunction

    task automatic random_request();
        logic [47:0] den;
        logic [47:0] num;
        logic [47:0] mult;
        int          kind;
        kind = $urandom_range(9);
        if (kind < 6)
        begin
            den = smooth_value(radix_now);
            mult = 48'($urandom_range(1, 50));
            if (den * mult > den) den = den * mult;
            if (den < 2) den = 2;
            num = 48'({$urandom, $urandom} % 64'(den));
            if (num == 0) num = 1;
        end
        else if (kind < 9)
        begin
            den = 48'({$urandom, $urandom});
            if (den == 0) den = 5;
            num = 48'({$urandom, $urandom} % 64'(den));
            if (num == 0) num = 1;
        end
        else
        begin
            num = 48'({$urandom, $urandom});
            den = ($urandom_range(3) == 0) ? 48'd0 : 48'({$urandom, $urandom});
        end
        send_request(num, den);
    endtask

    task automatic run_phase(int count);
        for (int k = 0; k < count; k++) random_request();
    endtask

    initial
    begin
        #400ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_request(0, 5);
        send_request(3, 0);
        send_request(0, 0);
        send_request(7, 7);
        send_request(9, 4);
        send_request(1, 8);
        send_request(1, 3);
        send_request(3, 6);
        send_request(48'hFFFF_FFFF_FFFE, 48'hFFFF_FFFF_FFFF);
        send_request(1, 48'h8000_0000_0000);
        send_request(48'hAAAA_AAAA_AAAA, 48'hFFFF_FFFF_FFFF);
        send_request(48'h5555_5555_5555, 48'hE8D4_A510_0000);
        write_radix(0);
        send_request(1, 2);
        write_radix(1);
        send_request(1, 2);
        write_radix(2);
        send_request(1, 1024);
        send_request(1, 6);
        write_radix(16'hFFFF);
        send_request(1, 48'd65535 * 48'd65535);
        send_request(2, 257);
        send_request(1, 7);
        write_radix(16'hFFFB);
        send_request(3, 48'd65531 * 48'd65531 * 48'd65531);
        send_request(3, 48'd65530);
        write_radix(12);
        send_idle = 19;
        recv_idle = 83;
        run_phase(25);
        hold_off = 400;
        for (int k = 0; k < 4; k++) send_request(1, 48'(1) << (k + 1));
        write_radix(16'h8000);
        send_idle = 83;
        recv_idle = 19;
        run_phase(20);
        write_radix($urandom_range(2, 100));
        send_idle = 0;
        recv_idle = 0;
        run_phase(20);
        write_radix(10);
        run_phase(10);
        in_valid <= 0;
        while (sb.finite_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("covered %0d requests, %0d results checked, radix 0 to 65535 and between",
                 sent, sb.checked);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire

// File: finite_radix_fraction_check_top.f
+incdir+hdl
hdl/frc_pkg.sv
hdl/frc_divider.sv
hdl/frc_datapath.sv
hdl/frc_controller.sv
hdl/finite_radix_fraction_check_top.sv
tb/finite_radix_fraction_check_top_tb.sv
